### rtl/dvc_pkg.sv
// dvc_pkg: shared types and constants for the divider voltage calibration block
// no dependencies
package dvc_pkg;

    localparam int unsigned SenseW = 16;
    localparam int unsigned ResW   = 20;
    localparam int unsigned TrimW  = 21;
    localparam int unsigned OutW   = 32;
    localparam int unsigned NumW   = 38;   // sense * total + bot/2 fits in 38 bits

    localparam logic [ResW-1:0] ResLimit = 20'd1000000;
    localparam logic [1:0] RegTop    = 2'd0;
    localparam logic [1:0] RegBottom = 2'd1;
    localparam logic [1:0] RegGain   = 2'd2;
    localparam logic [1:0] RegOffset = 2'd3;

    // reciprocal of 1e6: ceil(2^71 / 1e6), floor(x * r >> 71) is exact for x < 2^51
    localparam logic [51:0] PpmRecip = 52'd2361183241434823;
    localparam int unsigned PpmShift = 71;

    // payload handed from cell to cell of the divider row
    typedef struct packed {
        logic [NumW-1:0]   rem;    // partial remainder
        logic [NumW-1:0]   num;    // dividend bits still to shift in / quotient bits
        logic [ResW-1:0]   bot;
        logic [TrimW-1:0]  gain;
        logic [TrimW-1:0]  offset;
        logic              bad;
    } div_cell_t;

endpackage

### rtl/dvc_stream_if.sv
// dvc_stream_if: valid/ready channel with a parameterized payload
// no dependencies
interface dvc_stream_if #(parameter int unsigned W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/dvc_cfg_if.sv
// dvc_cfg_if: register write channel, index plus data
// no dependencies
interface dvc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/dvc_div_cell.sv
// dvc_div_cell: one restoring division step, registered, moves one quotient bit
// depends on dvc_pkg
module dvc_div_cell
    import dvc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  div_cell_t in_data,
    output logic      out_valid,
    output div_cell_t out_data
);
    logic            valid_reg;
    div_cell_t       data_reg;
    div_cell_t       data_next;
    logic [NumW:0]   trial;
    logic [NumW-1:0] shifted;

    always_comb
    begin
        data_next = in_data;
        shifted   = {in_data.rem[NumW-2:0], in_data.num[NumW-1]};
        trial     = {1'b0, shifted} - {{(NumW+1-ResW){1'b0}}, in_data.bot};
        data_next.num = {in_data.num[NumW-2:0], ~trial[NumW]};
        data_next.rem = trial[NumW] ? shifted : trial[NumW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

### rtl/dvc_trim.sv
// dvc_trim: clamp, gain trim and offset trim stages after the divider row
// depends on dvc_pkg
module dvc_trim
    import dvc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  div_cell_t       in_data,
    output logic            out_valid,
    output logic [OutW-1:0] vbat_mv,
    output logic            config_bad
);
    // stage 1: clamp quotient, multiply by gain
    logic [4:0]                 valid_reg;
    logic [30:0]                v1_reg;
    logic signed [52:0]         prod_reg;
    logic [TrimW-1:0]           off1_reg;
    logic                       bad1_reg;
    logic [30:0]                v_clamp;
    // stage 2: |prod|
    logic [30:0]                v2_reg;
    logic                       neg2_reg;
    logic [51:0]                mag2_reg;
    logic [TrimW-1:0]           off2_reg;
    logic                       bad2_reg;
    logic [51:0]                mag;
    // stage 3: |prod| * reciprocal, four partial products
    logic [30:0]                v3_reg;
    logic                       neg3_reg;
    logic [TrimW-1:0]           off3_reg;
    logic                       bad3_reg;
    logic [51:0]                pll_reg;
    logic [51:0]                plh_reg;
    logic [51:0]                phl_reg;
    logic [51:0]                phh_reg;
    logic [103:0]               full;
    // stage 4: quotient by 1e6
    logic [30:0]                v4_reg;
    logic                       neg4_reg;
    logic [TrimW-1:0]           off4_reg;
    logic                       bad4_reg;
    logic [32:0]                q4_reg;
    // stage 5
    logic [OutW-1:0]            out_reg;
    logic                       bad5_reg;
    logic signed [35:0]         sum;

    assign v_clamp = (|in_data.num[NumW-1:31]) ? 31'h7fffffff : in_data.num[30:0];
    assign mag = prod_reg[52] ? 52'(-prod_reg) : prod_reg[51:0];
    assign full = {52'd0, pll_reg} + {26'd0, plh_reg, 26'd0}
        + {26'd0, phl_reg, 26'd0} + {phh_reg, 52'd0};
    assign sum = $signed({5'd0, v4_reg})
        + (neg4_reg ? -$signed({3'd0, q4_reg}) : $signed({3'd0, q4_reg}))
        + 36'($signed(off4_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[3:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1_reg   <= v_clamp;
            prod_reg <= $signed({1'b0, v_clamp}) * $signed(in_data.gain);
            off1_reg <= in_data.offset;
            bad1_reg <= in_data.bad;

            v2_reg   <= v1_reg;
            neg2_reg <= prod_reg[52];
            mag2_reg <= mag;
            off2_reg <= off1_reg;
            bad2_reg <= bad1_reg;

            v3_reg   <= v2_reg;
            neg3_reg <= neg2_reg;
            off3_reg <= off2_reg;
            bad3_reg <= bad2_reg;
            pll_reg  <= {26'd0, mag2_reg[25:0]} * {26'd0, PpmRecip[25:0]};
            plh_reg  <= {26'd0, mag2_reg[25:0]} * {26'd0, PpmRecip[51:26]};
            phl_reg  <= {26'd0, mag2_reg[51:26]} * {26'd0, PpmRecip[25:0]};
            phh_reg  <= {26'd0, mag2_reg[51:26]} * {26'd0, PpmRecip[51:26]};

            v4_reg   <= v3_reg;
            neg4_reg <= neg3_reg;
            off4_reg <= off3_reg;
            bad4_reg <= bad3_reg;
            q4_reg   <= full[PpmShift +: 33];

            bad5_reg <= bad4_reg;
            if (bad4_reg || sum <= 0)
                out_reg <= '0;
            else if (sum[35:32] != 4'd0)
                out_reg <= '1;
            else
                out_reg <= sum[31:0];
        end
    end

    assign out_valid  = valid_reg[4];
    assign vbat_mv    = out_reg;
    assign config_bad = bad5_reg;
endmodule

### rtl/divider_voltage_calibrate.sv
// divider_voltage_calibrate: top level, config registers, divider cell row, trim stages
// depends on dvc_pkg, dvc_stream_if, dvc_cfg_if, dvc_div_cell, dvc_trim
//
// Takes one reading per clock while the output is not stalled and returns its battery
// voltage through a one-stage multiply/round front end, a row of 38 division cells (one
// quotient bit per cell) and five trim stages. The whole pipe advances when the output
// register is empty or being taken, so a stall on the output holds every stage. Register
// writes are accepted every cycle and must only occur while no reading is in flight.
module divider_voltage_calibrate
    import dvc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    dvc_cfg_if.sink                cfg,
    dvc_stream_if.sink             in_ch,
    dvc_stream_if.source           out_ch
);
    logic [ResW-1:0]  top_reg;
    logic [ResW-1:0]  bot_reg;
    logic [TrimW-1:0] gain_reg;
    logic [TrimW-1:0] offset_reg;
    logic             en;
    logic             fe_valid_reg;
    logic             bad_cfg;
    logic [NumW-1:0]  num_reg;
    logic             bad_reg;
    logic             out_valid;
    logic [OutW-1:0]  vbat_mv;
    logic             config_bad;
    logic [ResW:0]    total;

    logic      cell_valid [NumW+1];
    div_cell_t cell_data  [NumW+1];

    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg    <= '0;
            bot_reg    <= ResW'(1);
            gain_reg   <= '0;
            offset_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                RegTop:    top_reg    <= cfg.data[ResW-1:0];
                RegBottom: bot_reg    <= cfg.data[ResW-1:0];
                RegGain:   gain_reg   <= cfg.data[TrimW-1:0];
                RegOffset: offset_reg <= cfg.data[TrimW-1:0];
                default: ;
            endcase
        end
    end

    assign en = !out_valid || out_ch.ready;
    assign in_ch.ready = en;
    assign bad_cfg = (bot_reg == '0) || (top_reg > ResLimit) || (bot_reg > ResLimit);
    assign total = {1'b0, top_reg} + {1'b0, bot_reg};

    // front end: dividend = sense * total + bot/2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fe_valid_reg <= 1'b0;
        else if (en)
            fe_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= NumW'(in_ch.data) * NumW'(total) + NumW'(bot_reg[ResW-1:1]);
            bad_reg <= bad_cfg;
        end
    end

    assign cell_valid[0]       = fe_valid_reg;
    assign cell_data[0].rem    = '0;
    assign cell_data[0].num    = num_reg;
    assign cell_data[0].bot    = bot_reg;
    assign cell_data[0].gain   = gain_reg;
    assign cell_data[0].offset = offset_reg;
    assign cell_data[0].bad    = bad_reg;

    for (genvar i = 0; i < NumW; i++)
    begin : g_cell
        dvc_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (cell_valid[i]),
            .in_data   (cell_data[i]),
            .out_valid (cell_valid[i+1]),
            .out_data  (cell_data[i+1])
        );
    end

    dvc_trim u_trim (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (cell_valid[NumW]),
        .in_data    (cell_data[NumW]),
        .out_valid  (out_valid),
        .vbat_mv    (vbat_mv),
        .config_bad (config_bad)
    );

    assign out_ch.valid = out_valid;
    assign out_ch.data  = {vbat_mv, config_bad};
endmodule
